### hdl/rwc_pkg.sv
`default_nettype none

package rwc_pkg;

	localparam int unsigned WordW = 32;
	localparam int unsigned ShiftW = 5;

	localparam logic [WordW-1:0] CrcPoly = 32'hEDB88320;
	localparam logic [WordW-1:0] InitReset = 32'hFFFFFFFF;
	localparam logic [ShiftW-1:0] ClearReset = '0;

	typedef logic [0:0] cfg_idx_t;
	localparam cfg_idx_t REG_CLEAR_BITS = 1'b0;
	localparam cfg_idx_t REG_INIT_VALUE = 1'b1;

	typedef struct packed {
		logic [WordW-1:0] word_bits;
		logic             first;
		logic             last;
	} item_t;

	typedef struct packed {
		logic [WordW-1:0] crc_out;
		logic             done_res;
	} res_t;

	typedef logic [WordW-1:0] crc_cols_t [WordW];

	// reflected CRC-32 over one word, LSB first; elaboration use only
	function automatic logic [WordW-1:0] crc_serial(logic [WordW-1:0] acc,
			logic [WordW-1:0] data);
		logic [WordW-1:0] c;
		logic             fb;
		c = acc;
		for (int i = 0; i < WordW; i++) begin
			fb = c[0] ^ data[i];
			c = (c >> 1) ^ (fb ? CrcPoly : '0);
		end
		return c;
	endfunction

	// one column of the linear update per input bit
	function automatic crc_cols_t build_cols(bit data_side);
		crc_cols_t cols;
		logic [WordW-1:0] unit;
		for (int i = 0; i < WordW; i++) begin
			unit = '0;
			unit[i] = 1'b1;
			cols[i] = data_side ? crc_serial('0, unit) : crc_serial(unit, '0);
		end
		return cols;
	endfunction

	localparam crc_cols_t CrcAccCols = build_cols(1'b0);
	localparam crc_cols_t CrcDataCols = build_cols(1'b1);

endpackage

`default_nettype wire

### hdl/rounded_word_crc32.sv
`default_nettype none

// channel  dir  handshake                 payload
// item     in   item_valid / item_ready   item (rwc_pkg::item_t)
// res      out  res_valid / res_ready     res  (rwc_pkg::res_t)
// cfg      in   cfg_we                    cfg_index, cfg_data
//
// Items go through the input and result registers; one item per cycle unless res stalls.
// Rounding and the 32-bit CRC xor network sit between the input and result registers.
// The accumulator updates as an item moves into the result register.
// A stalled result holds the pipe; the input register keeps taking items while it has room.
// Reset empties both stages, accumulator and init_value go to all ones, clear_bits to 0.

module rounded_word_crc32 (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      item_valid,
	output logic                           item_ready,
	input  wire rwc_pkg::item_t            item,
	output logic                           res_valid,
	input  wire logic                      res_ready,
	output rwc_pkg::res_t                  res,
	input  wire logic                      cfg_we,
	input  wire rwc_pkg::cfg_idx_t         cfg_index,
	input  wire logic [rwc_pkg::WordW-1:0] cfg_data
);

	logic [rwc_pkg::ShiftW-1:0] clear_bits_q;
	logic [rwc_pkg::WordW-1:0]  init_value_q;
	logic [rwc_pkg::WordW-1:0]  acc_q;

	logic                       valid_s1;
	rwc_pkg::item_t             item_s1;
	logic                       res_valid_q;
	rwc_pkg::res_t              res_q;

	logic                       out_free;
	logic                       adv_s1;
	logic [rwc_pkg::WordW-1:0]  base;
	logic [rwc_pkg::WordW-1:0]  crc;
	logic [rwc_pkg::WordW-1:0]  crc_next;

	assign out_free = !res_valid_q || res_ready;
	assign adv_s1 = valid_s1 && out_free;
	assign item_ready = !valid_s1 || adv_s1;

	assign base = item_s1.first ? init_value_q : acc_q;
	assign crc_next = item_s1.last ? ~crc : crc;

	rwc_fold u_fold (
		.acc        (base),
		.word_bits  (item_s1.word_bits),
		.clear_bits (clear_bits_q),
		.crc        (crc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_bits_q <= rwc_pkg::ClearReset;
			init_value_q <= rwc_pkg::InitReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rwc_pkg::REG_CLEAR_BITS: clear_bits_q <= cfg_data[rwc_pkg::ShiftW-1:0];
				rwc_pkg::REG_INIT_VALUE: init_value_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			res_valid_q <= 1'b0;
			acc_q <= rwc_pkg::InitReset;
		end else begin
			if (item_ready) begin
				valid_s1 <= item_valid;
			end
			if (out_free) begin
				res_valid_q <= valid_s1;
			end
			if (adv_s1) begin
				acc_q <= crc_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
		if (adv_s1) begin
			res_q.crc_out <= crc_next;
			res_q.done_res <= item_s1.last;
		end
	end

	assign res_valid = res_valid_q;
	assign res = res_q;

endmodule

`default_nettype wire

### hdl/rwc_fold.sv
`default_nettype none

module rwc_fold (
	input  wire logic [rwc_pkg::WordW-1:0]  acc,
	input  wire logic [rwc_pkg::WordW-1:0]  word_bits,
	input  wire logic [rwc_pkg::ShiftW-1:0] clear_bits,
	output logic      [rwc_pkg::WordW-1:0]  crc
);

	logic [rwc_pkg::WordW-1:0] half;
	logic [rwc_pkg::WordW-1:0] mask;
	logic [rwc_pkg::WordW-1:0] rounded;

	always_comb begin
		half = '0;
		if (clear_bits != '0) begin
			half = {{(rwc_pkg::WordW-1){1'b0}}, 1'b1} << (clear_bits - 1'b1);
		end
		mask = {rwc_pkg::WordW{1'b1}} << clear_bits;
		rounded = (word_bits + half) & mask;
	end

	// CRC is linear: xor of precomputed columns for each set bit
	always_comb begin
		crc = '0;
		for (int i = 0; i < rwc_pkg::WordW; i++) begin
			crc = crc ^ (acc[i] ? rwc_pkg::CrcAccCols[i] : '0)
				^ (rounded[i] ? rwc_pkg::CrcDataCols[i] : '0);
		end
	end

endmodule

`default_nettype wire
